// ===== hw/rtl/nbs_pkg.sv =====
`default_nettype none

package nbs_pkg;

  localparam int unsigned PREFIX_LEN = 8;
  localparam int unsigned PFX_IDX_W  = $clog2(PREFIX_LEN);
  localparam int unsigned PUSH_W     = $clog2(PREFIX_LEN + 1);
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned LEN_W      = 25;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [LEN_W-1:0]   MAX_MSG_RST    = 25'd131076;
  localparam logic [CHUNK_W-1:0] MIN_RESYNC_RST = 16'd36;
  localparam logic [LEN_W-1:0]   HDR_OVERHEAD   = 25'd4;

  localparam logic [7:0] SYNC_TYPE      = 8'h00;
  localparam logic [7:0] SYNC_LEN_HI_MAX = 8'h01;
  localparam logic [7:0] MAGIC_0        = 8'hFF;
  localparam logic [7:0] MAGIC_1        = 8'h53;
  localparam logic [7:0] MAGIC_2        = 8'h4D;
  localparam logic [7:0] MAGIC_3        = 8'h42;

  typedef enum logic [1:0] {
    PH_RESYNC = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_MAGIC   = 2'd1,
    KIND_LENGTH  = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MSG    = 2'd0,
    CFG_MIN_RESYNC = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                req_type;
    logic [7:0]          data_byte;
    logic                chunk_start;
    logic [CHUNK_W-1:0]  chunk_bytes;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      result_kind;
    logic [7:0] frame_type;
    logic       last_in_message;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nbs_in_if.sv =====
`default_nettype none

interface nbs_in_if;
  import nbs_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         data_byte;
  logic               chunk_start;
  logic [CHUNK_W-1:0] chunk_bytes;

  modport source (
    output valid, req_type, data_byte, chunk_start, chunk_bytes,
    input  ready
  );

  modport sink (
    input  valid, req_type, data_byte, chunk_start, chunk_bytes,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/nbs_out_if.sv =====
`default_nettype none

interface nbs_out_if;
  import nbs_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [7:0] frame_type;
  logic       last_in_message;

  modport source (
    output valid, out_byte, result_kind, frame_type, last_in_message,
    input  ready
  );

  modport sink (
    input  valid, out_byte, result_kind, frame_type, last_in_message,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/nbs_cfg_if.sv =====
`default_nettype none

interface nbs_cfg_if;
  import nbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/netbios_session_framer.sv =====
`default_nettype none
// NetBIOS session message framer.
// in_i carries one stream byte (or a gap report) per transaction; out_o carries
// one result per transaction: a forwarded byte with its frame type and last
// mark, or a single error / discard code. cfg_i writes max_message_bytes
// (index 0) and min_resync_chunk (index 1); it is always ready and must only
// be used while the block is idle.
// An accepted item is registered, decoded once at least eight queue entries are
// free and its results are pushed into an output queue of FifoDepth entries
// (power of two, >= 16); results reach out_o from that queue.
// One item per cycle is sustained while the queue has room. A good header
// releases its eight bytes at once into the queue, which then drains one
// result per cycle while out_o is ready and body bytes keep arriving; the
// decode stage waits only while fewer than eight queue entries are free.
// Reset empties the queue, restores both registers to their defaults and
// puts the framer in resync wait. When the receiver stalls, results pile up
// in the queue and in_i.ready drops once it is nearly full.
module netbios_session_framer #(
  parameter int unsigned FifoDepth = nbs_pkg::FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nbs_in_if.sink    in_i,
  nbs_out_if.source out_o,
  nbs_cfg_if.sink   cfg_i
);
  import nbs_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [CntW-1:0] SpaceLimit = CntW'(FifoDepth - PREFIX_LEN);

  logic [LEN_W-1:0]   max_msg_q;
  logic [CHUNK_W-1:0] min_resync_q;

  item_t item_q;
  logic  s_vld_q, s_vld_d;
  logic  proc;
  logic  in_acc;

  phase_e             phase_q, phase_d;
  logic [7:0]         prefix_q [PREFIX_LEN];
  logic [7:0]         prefix_d [PREFIX_LEN];
  logic [7:0]         pre_w    [PREFIX_LEN];
  logic [LEN_W-1:0]   bc_q, bc_d, bc_inc;
  logic [LEN_W-1:0]   fl_q, fl_d;
  logic [7:0]         type_q, type_d;
  logic               pend_q, pend_d;

  logic [LEN_W-1:0] hdr_len;
  logic magic_ok, sync_ok, rel_short, body_last;
  logic is_data, ev_gap, cand, cand_short, ev_body, ev_hdr, hdr_done;
  logic fail_sync, chk, fail_len, fail_magic, ev_release;

  result_t             one_r;
  logic [PUSH_W-1:0]   push_n;
  result_t             fifo_q   [FifoDepth];
  result_t             wr_data  [FifoDepth];
  logic [FifoDepth-1:0] wr_en;
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                pop;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q    <= MAX_MSG_RST;
      min_resync_q <= MIN_RESYNC_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_MAX_MSG) begin
        max_msg_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_MIN_RESYNC) begin
        min_resync_q <= cfg_i.data[CHUNK_W-1:0];
      end
    end
  end

  // input register
  assign proc        = s_vld_q && (cnt_q <= SpaceLimit);
  assign in_i.ready  = !s_vld_q || proc;
  assign in_acc      = in_i.valid && in_i.ready;
  assign s_vld_d     = in_acc ? 1'b1 : (proc ? 1'b0 : s_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= s_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= '{req_type:    in_i.req_type,
                  data_byte:   in_i.data_byte,
                  chunk_start: in_i.chunk_start,
                  chunk_bytes: in_i.chunk_bytes};
    end
  end

  // decode
  always_comb begin
    pre_w = prefix_q;
    pre_w[bc_q[PFX_IDX_W-1:0]] = item_q.data_byte;
  end

  assign hdr_len   = LEN_W'({pre_w[1], pre_w[2], pre_w[3]}) + HDR_OVERHEAD;
  assign magic_ok  = (pre_w[4] == MAGIC_0) && (pre_w[5] == MAGIC_1) &&
                     (pre_w[6] == MAGIC_2) && (pre_w[7] == MAGIC_3);
  assign sync_ok   = (pre_w[0] == SYNC_TYPE) && (pre_w[1] <= SYNC_LEN_HI_MAX);
  assign rel_short = (hdr_len == LEN_W'(PREFIX_LEN));
  assign bc_inc    = bc_q + LEN_W'(1);
  assign body_last = (bc_inc >= fl_q);

  assign ev_gap     = proc && item_q.req_type;
  assign is_data    = proc && !item_q.req_type;
  assign cand       = is_data && item_q.chunk_start && (phase_q != PH_BODY) &&
                      ((phase_q != PH_HEADER) || pend_q);
  assign cand_short = cand && (item_q.chunk_bytes < min_resync_q);
  assign ev_body    = is_data && (phase_q == PH_BODY);
  assign ev_hdr     = is_data && (phase_q == PH_HEADER) && !cand;
  assign hdr_done   = ev_hdr && (bc_q == LEN_W'(PREFIX_LEN - 1));
  assign fail_sync  = hdr_done && pend_q && !(sync_ok && magic_ok);
  assign chk        = hdr_done && !fail_sync;
  assign fail_len   = chk && ((hdr_len > max_msg_q) || (hdr_len < LEN_W'(PREFIX_LEN)));
  assign fail_magic = chk && !fail_len && !magic_ok;
  assign ev_release = chk && !fail_len && magic_ok;

  // next state
  always_comb begin
    phase_d  = phase_q;
    prefix_d = prefix_q;
    bc_d     = bc_q;
    fl_d     = fl_q;
    type_d   = type_q;
    pend_d   = pend_q;

    if (ev_hdr) begin
      prefix_d = pre_w;
    end
    if (chk) begin
      type_d = pre_w[0];
      fl_d   = hdr_len;
      pend_d = 1'b0;
    end

    if (ev_gap || cand_short || fail_sync || fail_len || fail_magic) begin
      phase_d = PH_RESYNC;
      pend_d  = 1'b1;
      bc_d    = '0;
    end else if (cand) begin
      phase_d     = PH_HEADER;
      pend_d      = 1'b1;
      bc_d        = LEN_W'(1);
      prefix_d[0] = item_q.data_byte;
    end else if (ev_release) begin
      phase_d = rel_short ? PH_HEADER : PH_BODY;
      bc_d    = rel_short ? '0 : bc_inc;
    end else if (ev_body) begin
      phase_d = body_last ? PH_HEADER : PH_BODY;
      bc_d    = body_last ? '0 : bc_inc;
    end else if (ev_hdr) begin
      bc_d = bc_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RESYNC;
      bc_q    <= '0;
      fl_q    <= '0;
      type_q  <= '0;
      pend_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      fl_q    <= fl_d;
      type_q  <= type_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
  end

  // results
  always_comb begin
    push_n = '0;
    one_r  = '{out_byte: 8'h00, result_kind: KIND_DISCARD, frame_type: 8'h00,
               last_in_message: 1'b0};
    if (ev_body) begin
      push_n = PUSH_W'(1);
      one_r  = '{out_byte: item_q.data_byte, result_kind: KIND_DATA,
                 frame_type: type_q, last_in_message: body_last};
    end else if (cand_short || fail_sync) begin
      push_n = PUSH_W'(1);
    end else if (fail_len) begin
      push_n = PUSH_W'(1);
      one_r  = '{out_byte: 8'h00, result_kind: KIND_LENGTH, frame_type: pre_w[0],
                 last_in_message: 1'b0};
    end else if (fail_magic) begin
      push_n = PUSH_W'(1);
      one_r  = '{out_byte: 8'h00, result_kind: KIND_MAGIC, frame_type: pre_w[0],
                 last_in_message: 1'b0};
    end else if (ev_release) begin
      push_n = PUSH_W'(PREFIX_LEN);
    end
  end

  // output queue
  always_comb begin
    logic [PtrW-1:0] off;
    for (int j = 0; j < FifoDepth; j++) begin
      off        = PtrW'(j) - wr_ptr_q;
      wr_en[j]   = CntW'(off) < CntW'(push_n);
      wr_data[j] = one_r;
      if (ev_release) begin
        wr_data[j] = '{out_byte: pre_w[off[PFX_IDX_W-1:0]], result_kind: KIND_DATA,
                       frame_type: pre_w[0],
                       last_in_message: rel_short &&
                                        (off == PtrW'(PREFIX_LEN - 1))};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < FifoDepth; j++) begin
      if (wr_en[j]) begin
        fifo_q[j] <= wr_data[j];
      end
    end
  end

  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  assign out_o.valid           = (cnt_q != '0);
  assign out_o.out_byte        = fifo_q[rd_ptr_q].out_byte;
  assign out_o.result_kind     = fifo_q[rd_ptr_q].result_kind;
  assign out_o.frame_type      = fifo_q[rd_ptr_q].frame_type;
  assign out_o.last_in_message = fifo_q[rd_ptr_q].last_in_message;

endmodule

`default_nettype wire

// ===== hw/rtl/nbs_checker.sv =====
`default_nettype none

module nbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] result_kind,
  input logic [7:0] frame_type,
  input logic       last_in_message
);
  import nbs_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(result_kind) && $stable(frame_type) && $stable(last_in_message))
    else $error("stalled result changed or dropped");

  // input backpressure only comes from pending results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output queue");

  // error and discard results carry no byte and no last mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (result_kind != KIND_DATA) |-> (out_byte == 8'h00) && !last_in_message)
    else $error("non-data result carries payload");

  // discard results carry no frame type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (result_kind == KIND_DISCARD) |-> (frame_type == 8'h00))
    else $error("discard result carries frame type");

  // queue is empty right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind netbios_session_framer nbs_checker u_nbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_byte        (out_o.out_byte),
  .result_kind     (out_o.result_kind),
  .frame_type      (out_o.frame_type),
  .last_in_message (out_o.last_in_message)
);

`default_nettype wire
